/* rtl/core/tcor_pkg.sv */
// ----------------------------------------------------------------------------
// tcor_pkg: shared types and constants of the TTL cache
// Operation codes, default sizes and the structs that travel between the
// top level and the row of slot cells.
// ----------------------------------------------------------------------------
package tcor_pkg;

	// Default sizes.
	localparam int SLOTS_DEF       = 8;
	localparam int MAX_ENTRIES_DEF = 255;

	// Reset value of the time-to-live register, in milliseconds.
	localparam logic [15:0] TTL_RESET = 16'd2000;

	// Operation codes.
	localparam logic [1:0] OP_FIND  = 2'd0;
	localparam logic [1:0] OP_PUT   = 2'd1;
	localparam logic [1:0] OP_INVAL = 2'd2;

	// Request broadcast to every cell while an item is at work.
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] key;
		logic [31:0] now_ms;
		logic [15:0] ttl_ms;
	} tcor_req_t;

	// Write of a put into the chosen slot.
	typedef struct packed {
		logic        we;
		logic [31:0] key;
		logic [31:0] payload;
		logic [7:0]  count;
		logic [31:0] now_ms;
	} tcor_wr_t;

	// Search state handed from cell to cell.
	typedef struct packed {
		logic        active;
		logic        match_found;
		logic        empty_found;
		logic        hit;
		logic [31:0] best_age;
		logic [31:0] payload;
		logic [7:0]  count;
	} tcor_tok_t;

endpackage

/* rtl/core/tcor_ifs.sv */
// ----------------------------------------------------------------------------
// tcor_ifs: channel interfaces of the TTL cache
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one operation per item.
interface tcor_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] key;
	logic [31:0] payload;
	logic [7:0]  entries;
	logic [31:0] now_ms;

	modport source (output valid, operation, key, payload, entries, now_ms,
		input ready);
	modport sink (input valid, operation, key, payload, entries, now_ms,
		output ready);
endinterface

// Response channel: one result item per request item.
interface tcor_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [2:0]  slot_index;
	logic [31:0] payload_out;
	logic [7:0]  count_out;

	modport source (output valid, hit, slot_index, payload_out, count_out,
		input ready);
	modport sink (input valid, hit, slot_index, payload_out, count_out,
		output ready);
endinterface

// Configuration write channel for the time-to-live register.
interface tcor_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] ttl_ms;

	modport source (output valid, ttl_ms, input ready);
	modport sink (input valid, ttl_ms, output ready);
endinterface

/* rtl/core/tcor_cell.sv */
// ----------------------------------------------------------------------------
// tcor_cell: one cache slot of the cell row
// Holds one slot, checks the passing search state against it and hands the
// updated search state to the next cell through a register.
// ----------------------------------------------------------------------------
module tcor_cell import tcor_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IDX   = 0,
	localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tcor_req_t       req,
	input  tcor_wr_t        wr,
	input  logic [IW-1:0]   wr_idx,
	input  tcor_tok_t       tok_in,
	input  logic [IW-1:0]   mi_in,
	input  logic [IW-1:0]   ei_in,
	input  logic [IW-1:0]   bi_in,
	output tcor_tok_t       tok_q,
	output logic [IW-1:0]   mi_q,
	output logic [IW-1:0]   ei_q,
	output logic [IW-1:0]   bi_q
);

	localparam logic [IW-1:0] ME = IW'(IDX);

	logic        valid_q;
	logic [31:0] key_q;
	logic [31:0] time_q;
	logic [31:0] payload_q;
	logic [7:0]  count_q;

	logic [31:0]   age;
	logic          op_known;
	logic          match;
	logic          first;
	logic          expired;
	logic          clr;
	logic          wsel;
	tcor_tok_t     nxt;
	logic [IW-1:0] mi_d;
	logic [IW-1:0] ei_d;
	logic [IW-1:0] bi_d;

	// Match and age of this slot against the request.
	assign age      = req.now_ms - time_q;
	assign expired  = age > {16'd0, req.ttl_ms};
	assign op_known = req.op inside {OP_FIND, OP_PUT, OP_INVAL};
	assign match    = tok_in.active && op_known && valid_q && (key_q == req.key);
	assign first    = match && !tok_in.match_found;
	assign clr      = match && ((req.op == OP_INVAL) ||
		((req.op == OP_FIND) && first && expired));
	assign wsel     = wr.we && (wr_idx == ME);

	// Update of the search state as it passes this slot.
	always_comb begin
		nxt  = tok_in;
		mi_d = mi_in;
		ei_d = ei_in;
		bi_d = bi_in;
		// Invalidate reports the last match, the others the first one.
		if (match && (!tok_in.match_found || req.op == OP_INVAL)) begin
			nxt.match_found = 1'b1;
			mi_d            = ME;
		end
		if (first && req.op == OP_FIND && !expired) begin
			nxt.hit     = 1'b1;
			nxt.payload = payload_q;
			nxt.count   = count_q;
		end
		if (tok_in.active && !valid_q && !tok_in.empty_found) begin
			nxt.empty_found = 1'b1;
			ei_d            = ME;
		end
		// Oldest slot; the lowest index wins a tie.
		if (tok_in.active && (IDX == 0 || age > tok_in.best_age)) begin
			nxt.best_age = age;
			bi_d         = ME;
		end
	end

	// Valid bit and the hand-off register of the search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= nxt;
			if (wsel) begin
				valid_q <= 1'b1;
			end else if (clr) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Slot contents and the indices carried along with the search state.
	always_ff @(posedge clk) begin
		mi_q <= mi_d;
		ei_q <= ei_d;
		bi_q <= bi_d;
		if (wsel) begin
			key_q     <= wr.key;
			payload_q <= wr.payload;
			count_q   <= wr.count;
			time_q    <= wr.now_ms;
		end
	end

endmodule

/* rtl/core/ttl_cache_oldest_replace_unit.sv */
// ----------------------------------------------------------------------------
// ttl_cache_oldest_replace_unit: fully associative cache with time-to-live
// Top level: request capture, the row of slot cells, put write-back and the
// response register.
// ----------------------------------------------------------------------------
// Each item (find, put or invalidate) is captured at acceptance; its search
// state then walks down the row of slot cells, registered in each cell. As it
// leaves the last cell the put is committed and the result captured, and the
// result is loaded into the response register once that register is free.
// One item is at work at a time; the request side is ready again once the
// response register is loaded, so a new item is never accepted before the
// last one has reached the response register. The next request is taken
// even while the previous response still waits to be taken; that next item
// then holds after its commit until the response register is free. Finds
// hit only on a match no older than ttl_ms; an expired match is dropped. A
// put replaces a matching slot, else the first empty slot, else the oldest
// one. The slot valid bits clear at reset; no clearing pass is needed.
module ttl_cache_oldest_replace_unit import tcor_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	tcor_req_if.sink   req,
	tcor_rsp_if.source rsp,
	tcor_cfg_if.sink   cfg
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DONE} state_t;

	state_t      state_q;
	logic        start_q;
	logic [15:0] ttl_q;
	logic [1:0]  op_q;
	logic [31:0] key_q;
	logic [31:0] payload_q;
	logic [7:0]  count_q;
	logic [31:0] now_q;

	logic        res_hit_q;
	logic [2:0]  res_idx_q;
	logic [31:0] res_payload_q;
	logic [7:0]  res_count_q;

	logic        out_valid_q;
	logic        out_hit_q;
	logic [2:0]  out_idx_q;
	logic [31:0] out_payload_q;
	logic [7:0]  out_count_q;

	tcor_req_t     req_b;
	tcor_wr_t      wr;
	logic [IW-1:0] wr_idx;
	tcor_tok_t     link [SLOTS+1];
	logic [IW-1:0] mi   [SLOTS+1];
	logic [IW-1:0] ei   [SLOTS+1];
	logic [IW-1:0] bi   [SLOTS+1];
	logic [SLOTS:0] act;
	logic          accept;
	logic          commit;
	logic          out_free;
	tcor_tok_t     fin;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.slot_index  = out_idx_q;
	assign rsp.payload_out = out_payload_q;
	assign rsp.count_out   = out_count_q;

	// Request seen by every cell.
	assign req_b = '{op: op_q, key: key_q, now_ms: now_q, ttl_ms: ttl_q};

	// Fresh search state entering the first cell.
	assign link[0] = '{active: start_q, match_found: 1'b0, empty_found: 1'b0,
		hit: 1'b0, best_age: 32'd0, payload: 32'd0, count: 8'd0};
	assign mi[0] = '0;
	assign ei[0] = '0;
	assign bi[0] = '0;

	// Row of slot cells.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		tcor_cell #(.SLOTS(SLOTS), .IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req_b),
			.wr     (wr),
			.wr_idx (wr_idx),
			.tok_in (link[i]),
			.mi_in  (mi[i]),
			.ei_in  (ei[i]),
			.bi_in  (bi[i]),
			.tok_q  (link[i+1]),
			.mi_q   (mi[i+1]),
			.ei_q   (ei[i+1]),
			.bi_q   (bi[i+1])
		);
	end

	for (genvar i = 0; i <= SLOTS; i++) begin : g_act
		assign act[i] = link[i].active;
	end

	// Search state leaving the last cell, and the put target it selects.
	assign fin    = link[SLOTS];
	assign commit = fin.active;
	always_comb begin
		if (fin.match_found) begin
			wr_idx = mi[SLOTS];
		end else if (fin.empty_found) begin
			wr_idx = ei[SLOTS];
		end else begin
			wr_idx = bi[SLOTS];
		end
	end
	assign wr = '{we: commit && (op_q == OP_PUT), key: key_q, payload: payload_q,
		count: count_q, now_ms: now_q};

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			ttl_q <= cfg.ttl_ms;
		end
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (commit) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured request, result and response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.operation;
			key_q     <= req.key;
			payload_q <= req.payload;
			now_q     <= req.now_ms;
			count_q   <= ({24'd0, req.entries} > MAX_ENTRIES) ?
				8'(MAX_ENTRIES) : req.entries;
		end
		if (commit) begin
			res_hit_q     <= fin.hit && (op_q == OP_FIND);
			res_idx_q     <= (op_q == OP_PUT) ? 3'(wr_idx) : 3'(mi[SLOTS]);
			res_payload_q <= fin.payload;
			res_count_q   <= fin.count;
		end
		if (state_q == S_DONE && out_free) begin
			out_hit_q     <= res_hit_q;
			out_idx_q     <= res_idx_q;
			out_payload_q <= res_payload_q;
			out_count_q   <= res_count_q;
		end
	end

	// At most one item is in the cell row at any time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act))
		else $error("more than one item in the cell row");

	// The search state leaves the row only while the sequencer sweeps.
	a_commit_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> state_q == S_SWEEP)
		else $error("commit outside of a sweep");

	// An accepted request starts a sweep in the next cycle.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> start_q && state_q == S_SWEEP)
		else $error("accepted item did not start a sweep");

endmodule
